// ----- hw/rtl/cbam_pkg.sv -----
// ----------------------------------------------------------------------------
// cbam_pkg
// Shared types and constants for the cartridge bank address mapper: access
// request layout, region codes, controller kinds and address map limits.
// ----------------------------------------------------------------------------
package cbam_pkg;

    // Memory region reported for each access
    typedef enum logic [1:0] {
        REGION_BOOT = 2'd0,
        REGION_ROM  = 2'd1,
        REGION_ERAM = 2'd2,
        REGION_NONE = 2'd3
    } t_region;

    // Bank controller kind, set by the configuration register
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_MBC1     = 2'd1,
        KIND_MBC1_RAM = 2'd2,
        KIND_MBC3     = 2'd3
    } t_kind;

    // Control write target, address bits 14:13 of a write below 0x8000
    typedef enum logic [1:0] {
        CMD_RAM_ENABLE = 2'd0,
        CMD_ROM_BANK   = 2'd1,
        CMD_UPPER      = 2'd2,
        CMD_MODE       = 2'd3
    } t_cmd;

    // One bus access request
    typedef struct packed {
        logic        is_write;
        logic [15:0] addr;
        logic [7:0]  wbyte;
        logic [15:0] pc;
    } t_req;

    // Single-bit controller flags
    typedef struct packed {
        logic boot_overlay;
        logic ram_enable;
        logic banking_mode;
    } t_flags;

    localparam int unsigned PHYS_W     = 21;
    localparam int unsigned BANK_OUT_W = 7;

    localparam logic [15:0] ROM_WINDOW_BASE = 16'h4000;
    localparam logic [15:0] ERAM_BASE       = 16'hA000;
    localparam logic [15:0] ERAM_END        = 16'hC000;
    localparam logic [15:0] CTRL_END        = 16'h8000;
    localparam logic [15:0] OVERLAY_END     = 16'h1000;
    localparam logic [15:0] BOOT_PC_MIN     = 16'h0100;
    localparam logic [15:0] BOOT_ROM_END    = 16'h0100;
    localparam logic [7:0]  RAM_ENABLE_KEY  = 8'h0A;
    localparam logic [6:0]  LOW5_MASK       = 7'h1F;
    localparam logic [6:0]  HIGH2_MASK      = 7'h60;
    localparam logic [6:0]  BANK7_MASK      = 7'h7F;
    localparam int unsigned ROM_OFS_W       = 14;
    localparam int unsigned RAM_OFS_W       = 13;

    localparam t_flags FLAGS_RESET = '{boot_overlay: 1'b1, ram_enable: 1'b0,
                                       banking_mode: 1'b0};

endpackage

// ----- hw/rtl/cartridge_bank_address_mapper.sv -----
// ----------------------------------------------------------------------------
// cartridge_bank_address_mapper
// Cartridge bank controller and address mapper for one CPU bus access per
// cycle unless stalled, with boot ROM overlay and selectable controller kind.
// ----------------------------------------------------------------------------
// Each request passes an input register and then a result register. One
// request can be accepted every cycle unless the result side stalls; the
// decode between the two registers, which also feeds the bank register
// update, is combinational. Write the controller kind only while no request
// is in flight. Physical addresses are 21 bits (2 MB ROM window); RAM enable
// is reported but does not gate accesses.
module cartridge_bank_address_mapper
    import cbam_pkg::*;
#(
    parameter int unsigned ROM_BANK_BITS  = 7,
    parameter int unsigned RAM_BANK_BITS  = 2,
    parameter int unsigned BOOT_ROM_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_is_write,
    input  logic [15:0]       i_bus_address,
    input  logic [7:0]        i_write_byte,
    input  logic [15:0]       i_program_counter,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_region,
    output logic [PHYS_W-1:0] o_physical_address,
    output logic              o_ext_ram_write,
    output logic [7:0]        o_data_out,
    output logic              o_ram_enabled,
    output logic [6:0]        o_current_rom_bank
);

    // boot ROM spans the first BOOT_ROM_BYTES bytes of the address space
    localparam logic [15:0] BOOT_LIMIT = 16'(BOOT_ROM_BYTES);

    logic                     r_s1_valid;
    t_req                     r_s1_req;
    logic                     r_out_valid;
    t_region                  r_region;
    logic [PHYS_W-1:0]        r_phys;
    logic                     r_ram_write;
    logic [7:0]               r_data;
    logic                     r_ram_en;
    logic [6:0]               r_rom_bank;

    logic                     step;
    t_kind                    kind;
    t_flags                   flags, next_flags;
    logic [ROM_BANK_BITS-1:0] window_bank, next_rom_bank;
    logic [RAM_BANK_BITS-1:0] ram_bank;
    t_region                  region;
    logic [PHYS_W-1:0]        phys;
    logic                     ram_write;
    logic [7:0]               data;
    logic [ROM_BANK_BITS+6:0] bank_ext;
    logic                     boot_view;

    // Handshake: stage 2 moves when the result register is free or drained
    assign step       = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_req <= '{is_write: i_is_write, addr: i_bus_address,
                          wbyte: i_write_byte, pc: i_program_counter};
        end
    end

    cbam_ctrl #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_step          (step),
        .i_req           (r_s1_req),
        .o_kind          (kind),
        .o_flags         (flags),
        .o_window_bank   (window_bank),
        .o_ram_bank      (ram_bank),
        .o_next_flags    (next_flags),
        .o_next_rom_bank (next_rom_bank)
    );

    // overlay only matters inside the boot ROM span
    assign boot_view = flags.boot_overlay && (r_s1_req.addr < BOOT_LIMIT);

    cbam_map #(
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_BANK_BITS (RAM_BANK_BITS)
    ) u_map (
        .i_req          (r_s1_req),
        .i_kind         (kind),
        .i_boot_overlay (boot_view),
        .i_window_bank  (window_bank),
        .i_ram_bank     (ram_bank),
        .o_region       (region),
        .o_phys         (phys),
        .o_ram_write    (ram_write),
        .o_data         (data)
    );

    assign bank_ext = {7'd0, next_rom_bank};

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_region    <= region;
            r_phys      <= phys;
            r_ram_write <= ram_write;
            r_data      <= data;
            r_ram_en    <= next_flags.ram_enable;
            r_rom_bank  <= bank_ext[6:0];
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_region           = r_region;
    assign o_physical_address = r_phys;
    assign o_ext_ram_write    = r_ram_write;
    assign o_data_out         = r_data;
    assign o_ram_enabled      = r_ram_en;
    assign o_current_rom_bank = r_rom_bank;

endmodule

// ----- hw/rtl/cbam_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbam_ctrl
// Bank controller state: controller kind, boot overlay, ROM and RAM bank
// registers, RAM enable and banking mode. Applies control writes and the
// boot overlay exit for each request that leaves the input stage.
// ----------------------------------------------------------------------------
module cbam_ctrl
    import cbam_pkg::*;
#(
    parameter int unsigned ROM_BANK_BITS = 7,
    parameter int unsigned RAM_BANK_BITS = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_data,
    input  logic                     i_step,
    input  t_req                     i_req,
    output t_kind                    o_kind,
    output t_flags                   o_flags,
    output logic [ROM_BANK_BITS-1:0] o_window_bank,
    output logic [RAM_BANK_BITS-1:0] o_ram_bank,
    output t_flags                   o_next_flags,
    output logic [ROM_BANK_BITS-1:0] o_next_rom_bank
);

    t_kind                     r_kind;
    t_flags                    r_flags, n_flags;
    logic [ROM_BANK_BITS-1:0]  r_rom_bank, n_rom_bank;
    logic [ROM_BANK_BITS-1:0]  r_window, n_window;
    logic [RAM_BANK_BITS-1:0]  r_ram_bank, n_ram_bank;

    logic [ROM_BANK_BITS+6:0]  cur_ext;
    logic [6:0]                cur7;
    logic [6:0]                lo5, lo7, bank7;
    logic [ROM_BANK_BITS+6:0]  bank_fit;
    logic [ROM_BANK_BITS-1:0]  win;
    logic [RAM_BANK_BITS+7:0]  ram_fit;
    logic                      ctrl_wr;
    t_cmd                      cmd;
    logic                      bank_upd;

    // Current ROM bank viewed as seven bits
    assign cur_ext = {7'd0, r_rom_bank};
    assign cur7    = cur_ext[6:0];

    // Candidate low bank values with the zero-to-one fixup
    always_comb begin
        lo5 = {2'b00, i_req.wbyte[4:0]};
        if (lo5 == 7'd0) begin
            lo5 = 7'd1;
        end
        lo7 = i_req.wbyte[6:0];
        if (lo7 == 7'd0) begin
            lo7 = 7'd1;
        end
    end

    assign ctrl_wr = i_req.is_write && (r_kind != KIND_NONE) && (i_req.addr < CTRL_END);
    assign cmd     = t_cmd'(i_req.addr[14:13]);
    assign ram_fit = {RAM_BANK_BITS'(0), i_req.wbyte};

    // Control write decode
    always_comb begin
        n_flags    = r_flags;
        n_ram_bank = r_ram_bank;
        bank7      = cur7;
        bank_upd   = 1'b0;
        if (i_step) begin
            // boot overlay exit on a low ROM read past the boot area
            if (!i_req.is_write && r_flags.boot_overlay && (i_req.addr >= BOOT_ROM_END)
                && (i_req.addr < OVERLAY_END) && (i_req.pc >= BOOT_PC_MIN)) begin
                n_flags.boot_overlay = 1'b0;
            end
            if (ctrl_wr) begin
                case (cmd)
                    CMD_RAM_ENABLE: begin
                        if (r_kind == KIND_MBC1_RAM || r_kind == KIND_MBC3) begin
                            n_flags.ram_enable = (i_req.wbyte == RAM_ENABLE_KEY);
                        end
                    end
                    CMD_ROM_BANK: begin
                        bank_upd = 1'b1;
                        if (r_kind == KIND_MBC3) begin
                            bank7 = lo7;
                        end else begin
                            bank7 = (cur7 & HIGH2_MASK) | lo5;
                        end
                    end
                    CMD_UPPER: begin
                        if (r_kind == KIND_MBC3) begin
                            if (i_req.wbyte <= 8'd3) begin
                                n_ram_bank = ram_fit[RAM_BANK_BITS-1:0];
                            end
                        end else if (r_flags.banking_mode) begin
                            n_ram_bank = ram_fit[RAM_BANK_BITS-1:0] &
                                         RAM_BANK_BITS'(2'b11);
                        end else begin
                            bank_upd = 1'b1;
                            bank7    = (cur7 & LOW5_MASK) | {i_req.wbyte[1:0], 5'd0};
                        end
                    end
                    CMD_MODE: begin
                        if (r_kind == KIND_MBC1_RAM) begin
                            n_flags.banking_mode = i_req.wbyte[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Fit the seven-bit result into the bank register and follow the window
    assign bank_fit = {ROM_BANK_BITS'(0), bank7};
    always_comb begin
        n_rom_bank = r_rom_bank;
        n_window   = r_window;
        win        = bank_fit[ROM_BANK_BITS-1:0];
        if (r_kind != KIND_MBC3 && win[4:0] == 5'd0) begin
            win[0] = 1'b1;
        end
        if (bank_upd) begin
            n_rom_bank = bank_fit[ROM_BANK_BITS-1:0];
            n_window   = win;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_NONE;
            r_flags    <= FLAGS_RESET;
            r_rom_bank <= '0;
            r_window   <= ROM_BANK_BITS'(1);
            r_ram_bank <= '0;
        end else begin
            if (i_cfg_we) begin
                r_kind <= t_kind'(i_cfg_data);
            end
            r_flags    <= n_flags;
            r_rom_bank <= n_rom_bank;
            r_window   <= n_window;
            r_ram_bank <= n_ram_bank;
        end
    end

    assign o_kind          = r_kind;
    assign o_flags         = r_flags;
    assign o_window_bank   = r_window;
    assign o_ram_bank      = r_ram_bank;
    assign o_next_flags    = n_flags;
    assign o_next_rom_bank = n_rom_bank;

endmodule

// ----- hw/rtl/cbam_map.sv -----
// ----------------------------------------------------------------------------
// cbam_map
// Address translation: picks the region for a request and forms the
// physical byte address from the current bank registers.
// ----------------------------------------------------------------------------
module cbam_map
    import cbam_pkg::*;
#(
    parameter int unsigned ROM_BANK_BITS = 7,
    parameter int unsigned RAM_BANK_BITS = 2
) (
    input  t_req                     i_req,
    input  t_kind                    i_kind,
    input  logic                     i_boot_overlay,
    input  logic [ROM_BANK_BITS-1:0] i_window_bank,
    input  logic [RAM_BANK_BITS-1:0] i_ram_bank,
    output t_region                  o_region,
    output logic [PHYS_W-1:0]        o_phys,
    output logic                     o_ram_write,
    output logic [7:0]               o_data
);

    localparam int unsigned ROM_W = ROM_BANK_BITS + ROM_OFS_W + PHYS_W;
    localparam int unsigned RAM_W = RAM_BANK_BITS + RAM_OFS_W + PHYS_W;

    logic             is_eram;
    logic [ROM_W-1:0] rom_full;
    logic [RAM_W-1:0] ram_full;
    logic [PHYS_W-1:0] rom_phys, ram_phys;

    assign is_eram  = (i_req.addr >= ERAM_BASE) && (i_req.addr < ERAM_END);
    assign rom_full = {PHYS_W'(0), i_window_bank, i_req.addr[ROM_OFS_W-1:0]};
    assign ram_full = {PHYS_W'(0), i_ram_bank, i_req.addr[RAM_OFS_W-1:0]};
    assign rom_phys = rom_full[PHYS_W-1:0];
    assign ram_phys = ram_full[PHYS_W-1:0];

    // Region and address select
    always_comb begin
        o_region    = REGION_NONE;
        o_phys      = '0;
        o_ram_write = 1'b0;
        o_data      = '0;
        if (i_req.is_write) begin
            if (i_kind != KIND_NONE && i_req.addr >= CTRL_END && is_eram) begin
                o_region    = REGION_ERAM;
                o_phys      = ram_phys;
                o_ram_write = 1'b1;
                o_data      = i_req.wbyte;
            end
        end else if (i_req.addr < ROM_WINDOW_BASE) begin
            o_region = REGION_ROM;
            o_phys   = {5'd0, i_req.addr};
            if (i_boot_overlay && i_req.addr < BOOT_ROM_END) begin
                o_region = REGION_BOOT;
            end
        end else if (i_req.addr < CTRL_END) begin
            o_region = REGION_ROM;
            o_phys   = rom_phys;
        end else if (is_eram) begin
            o_region = REGION_ERAM;
            o_phys   = ram_phys;
        end
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the cartridge bank address mapper. Requests go
// in on a valid/ready channel with random gaps. Each accepted request is run
// through a behavioral mapper model that predicts the region, physical address,
// RAM write strobe and bank state. Each result is then checked in order
// against that prediction, while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import cbam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected or observed mapping for one request
    typedef struct packed {
        t_region           region;
        logic [PHYS_W-1:0] phys;
        logic              ram_wr;
        logic [7:0]        data;
        logic              ram_en;
        logic [6:0]        bank;
    } t_map_result;

    // Mapper model plus in-order store of predicted mappings
    class mapper_scoreboard;
        t_kind       kind;
        logic        overlay;
        logic        ram_enable;
        logic        mode;
        logic [6:0]  rom_bank;
        logic [6:0]  window_bank;
        logic [1:0]  ram_bank;
        t_map_result expected_q[$];
        int unsigned mismatches;
        int unsigned orphans;
        int unsigned checked;
        int unsigned region_hits[4];
        int unsigned eram_writes;

        function new();
            kind        = KIND_NONE;
            overlay     = 1'b1;
            ram_enable  = 1'b0;
            mode        = 1'b0;
            rom_bank    = 7'd0;
            window_bank = 7'd1;
            ram_bank    = 2'd0;
            mismatches  = 0;
            orphans     = 0;
            checked     = 0;
            eram_writes = 0;
            foreach (region_hits[i]) region_hits[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Window follows the bank; the first controller maps low bits 0 to 1
        function void refresh_window();
            logic [6:0] b;
            b = rom_bank;
            if (kind != KIND_MBC3 && b[4:0] == 5'd0) b[0] = 1'b1;
            window_bank = b;
        endfunction

        function void bank_command(t_cmd cmd, logic [7:0] val);
            logic [6:0] low;
            case (cmd)
                CMD_RAM_ENABLE: begin
                    if (kind == KIND_MBC1_RAM || kind == KIND_MBC3)
                        ram_enable = (val == RAM_ENABLE_KEY);
                end
                CMD_ROM_BANK: begin
                    if (kind == KIND_MBC3) begin
                        low = val[6:0];
                        if (low == 7'd0) low = 7'd1;
                        rom_bank = low;
                    end else begin
                        low = {2'b00, val[4:0]};
                        if (low == 7'd0) low = 7'd1;
                        rom_bank = (rom_bank & HIGH2_MASK) | low;
                    end
                    refresh_window();
                end
                CMD_UPPER: begin
                    if (kind == KIND_MBC3) begin
                        // values above 3 select RTC registers, not modeled
                        if (val <= 8'd3) ram_bank = val[1:0];
                    end else if (mode) begin
                        ram_bank = val[1:0];
                    end else begin
                        rom_bank = {val[1:0], rom_bank[4:0]};
                        refresh_window();
                    end
                end
                CMD_MODE: begin
                    if (kind == KIND_MBC1_RAM) mode = val[0];
                end
                default: begin
                end
            endcase
        endfunction

        // Predict the mapping of an accepted request and queue it
        function void note_request(t_req r);
            t_map_result res;
            logic        in_eram;
            logic [20:0] eram_addr;
            res       = '0;
            res.region = REGION_NONE;
            in_eram   = (r.addr >= ERAM_BASE) && (r.addr < ERAM_END);
            eram_addr = {6'd0, ram_bank, r.addr[12:0]};
            if (r.is_write) begin
                if (kind != KIND_NONE) begin
                    if (r.addr < CTRL_END) begin
                        bank_command(t_cmd'(r.addr[14:13]), r.wbyte);
                    end else if (in_eram) begin
                        res.region = REGION_ERAM;
                        res.phys   = eram_addr;
                        res.ram_wr = 1'b1;
                        res.data   = r.wbyte;
                    end
                end
            end else if (r.addr < ROM_WINDOW_BASE) begin
                res.region = REGION_ROM;
                res.phys   = {5'd0, r.addr};
                // boot overlay covers the first 256 bytes until the hand-off read
                if (r.addr < OVERLAY_END && overlay) begin
                    if (r.addr < BOOT_ROM_END) res.region = REGION_BOOT;
                    else if (r.pc >= BOOT_PC_MIN) overlay = 1'b0;
                end
            end else if (r.addr < CTRL_END) begin
                res.region = REGION_ROM;
                res.phys   = {window_bank, r.addr[13:0]};
            end else if (in_eram) begin
                res.region = REGION_ERAM;
                res.phys   = eram_addr;
            end
            res.ram_en = ram_enable;
            res.bank   = rom_bank;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [20:0] want, logic [20:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                             checked, field, want, got);
            end
        endfunction

        function void check_result(t_map_result got);
            t_map_result want;
            if (expected_q.size() == 0) begin
                orphans++;
                $display("ERROR: result with no request outstanding");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            region_hits[want.region]++;
            if (want.ram_wr) eram_writes++;
            compare_field("region", 21'(want.region), 21'(got.region));
            compare_field("physical_address", want.phys, got.phys);
            compare_field("ext_ram_write", 21'(want.ram_wr), 21'(got.ram_wr));
            compare_field("data_out", 21'(want.data), 21'(got.data));
            compare_field("ram_enabled", 21'(want.ram_en), 21'(got.ram_en));
            compare_field("current_rom_bank", 21'(want.bank), 21'(got.bank));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n           = 1'b0;
    logic              i_cfg_we          = 1'b0;
    logic [1:0]        i_cfg_data        = 2'd0;
    logic              i_in_valid        = 1'b0;
    logic              o_in_ready;
    logic              i_is_write        = 1'b0;
    logic [15:0]       i_bus_address     = 16'd0;
    logic [7:0]        i_write_byte      = 8'd0;
    logic [15:0]       i_program_counter = 16'd0;
    logic              o_out_valid;
    logic              i_out_ready       = 1'b0;
    logic [1:0]        o_region;
    logic [PHYS_W-1:0] o_physical_address;
    logic              o_ext_ram_write;
    logic [7:0]        o_data_out;
    logic              o_ram_enabled;
    logic [6:0]        o_current_rom_bank;

    logic              no_idle = 1'b0;
    mapper_scoreboard  sb      = new();
    t_map_result       seen;

    cartridge_bank_address_mapper dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_is_write         (i_is_write),
        .i_bus_address      (i_bus_address),
        .i_write_byte       (i_write_byte),
        .i_program_counter  (i_program_counter),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_region           (o_region),
        .o_physical_address (o_physical_address),
        .o_ext_ram_write    (o_ext_ram_write),
        .o_data_out         (o_data_out),
        .o_ram_enabled      (o_ram_enabled),
        .o_current_rom_bank (o_current_rom_bank)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.region = t_region'(o_region);
            seen.phys   = o_physical_address;
            seen.ram_wr = o_ext_ram_write;
            seen.data   = o_data_out;
            seen.ram_en = o_ram_enabled;
            seen.bank   = o_current_rom_bank;
            sb.check_result(seen);
        end
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 31);
    end

    function automatic t_req bus_access(logic w, logic [15:0] a, logic [7:0] b,
                                        logic [15:0] pc);
        t_req r;
        r.is_write = w;
        r.addr     = a;
        r.wbyte    = b;
        r.pc       = pc;
        return r;
    endfunction

    // Mostly well-formed bank traffic, some fully random noise
    function automatic t_req random_request();
        t_req        r;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        r.is_write = 1'b0;
        r.addr     = 16'($urandom);
        r.wbyte    = 8'($urandom);
        r.pc       = 16'($urandom);
        if (pick < 30) begin
            r.is_write = 1'b1;
            r.addr     = 16'($urandom_range(0, 16'h7FFF));
            case ($urandom_range(0, 4))
                0:       r.wbyte = RAM_ENABLE_KEY;
                1:       r.wbyte = 8'($urandom_range(0, 3));
                2:       r.wbyte = 8'h00;
                default: ;
            endcase
        end else if (pick < 45) begin
            r.is_write = 1'b1;
            r.addr     = 16'($urandom_range(ERAM_BASE, ERAM_END - 1));
        end else if (pick < 85) begin
            r.addr     = 16'($urandom_range(0, 16'hBFFF));
        end else begin
            r.is_write = 1'($urandom);
        end
        return r;
    endfunction

    // Present one request after an optional gap, wait for acceptance
    task automatic send_request(t_req r);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 31) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid        <= 1'b1;
        i_is_write        <= r.is_write;
        i_bus_address     <= r.addr;
        i_write_byte      <= r.wbyte;
        i_program_counter <= r.pc;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    // Hold off requests until every predicted mapping has come back
    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apply_kind(t_kind k);
        drain_requests();
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.kind = k;
    endtask

    // Stimulus
    initial begin
        t_kind       plan[6];
        int unsigned failures;
        plan = '{KIND_MBC1, KIND_MBC3, KIND_MBC1_RAM, KIND_NONE, KIND_MBC3,
                 KIND_MBC1_RAM};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No banking: boot overlay, ignored writes, overlay hand-off
        apply_kind(KIND_NONE);
        send_request(bus_access(1'b0, 16'h0000, 8'h00, 16'h0000));
        send_request(bus_access(1'b0, 16'h00FF, 8'hFF, 16'hFFFF));
        send_request(bus_access(1'b0, 16'h0100, 8'h00, 16'h00FF));
        send_request(bus_access(1'b1, 16'h2000, 8'h05, 16'h0000));
        send_request(bus_access(1'b1, 16'hA000, 8'hFF, 16'h0000));
        send_request(bus_access(1'b0, 16'h4000, 8'h00, 16'h1234));
        send_request(bus_access(1'b0, 16'hBFFF, 8'h00, 16'h0000));
        send_request(bus_access(1'b0, 16'hFFFF, 8'h00, 16'h0000));
        send_request(bus_access(1'b0, 16'h0FFF, 8'h00, 16'h0100));
        send_request(bus_access(1'b0, 16'h0000, 8'h00, 16'h0000));

        // First controller with RAM: zero low bank bits, enable key, modes
        apply_kind(KIND_MBC1_RAM);
        send_request(bus_access(1'b1, 16'h4000, 8'h02, 16'h0000));
        send_request(bus_access(1'b0, 16'h7FFF, 8'h00, 16'h0000));
        send_request(bus_access(1'b1, 16'h0000, 8'h0A, 16'h0000));
        send_request(bus_access(1'b1, 16'h1FFF, 8'h0B, 16'h0000));
        send_request(bus_access(1'b1, 16'h3FFF, 8'hFF, 16'h0000));
        send_request(bus_access(1'b1, 16'h2000, 8'hE0, 16'h0000));
        send_request(bus_access(1'b1, 16'h6000, 8'h01, 16'h0000));
        send_request(bus_access(1'b1, 16'h5FFF, 8'hFE, 16'h0000));
        send_request(bus_access(1'b1, 16'hBFFF, 8'h5A, 16'h0000));
        send_request(bus_access(1'b1, 16'h8000, 8'h11, 16'h0000));
        send_request(bus_access(1'b1, 16'h7FFF, 8'h00, 16'h0000));

        // Seven-bit controller: bank zero, full bank, RAM bank range
        apply_kind(KIND_MBC3);
        send_request(bus_access(1'b1, 16'h2000, 8'h80, 16'h0000));
        send_request(bus_access(1'b1, 16'h2000, 8'hFF, 16'h0000));
        send_request(bus_access(1'b1, 16'h4000, 8'h04, 16'h0000));
        send_request(bus_access(1'b1, 16'h4000, 8'h03, 16'h0000));
        send_request(bus_access(1'b0, 16'hA000, 8'h00, 16'h0000));
        send_request(bus_access(1'b1, 16'h0000, 8'h0A, 16'h0000));

        // Random phases over every controller kind
        for (int p = 0; p < 7; p++) begin
            apply_kind(p < 6 ? plan[p] : t_kind'($urandom_range(0, 3)));
            no_idle <= (p == 1);
            for (int n = 0; n < 190; n++) begin
                if (p == 2 && n == 95) drain_requests();
                send_request(random_request());
            end
        end

        drain_requests();
        no_idle <= 1'b0;
        repeat (4) @(posedge i_clk);

        failures = sb.mismatches + sb.orphans + sb.pending();
        $display("Checked %0d mappings across all controller kinds: %0d boot ROM,",
                 sb.checked, sb.region_hits[REGION_BOOT]);
        $display("%0d cartridge ROM, %0d external RAM (%0d writes), %0d unmapped",
                 sb.region_hits[REGION_ROM], sb.region_hits[REGION_ERAM],
                 sb.eram_writes, sb.region_hits[REGION_NONE]);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d unexpected results", sb.mismatches, sb.orphans);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- cartridge_bank_address_mapper.f -----
hw/rtl/cbam_pkg.sv
hw/rtl/cbam_ctrl.sv
hw/rtl/cbam_map.sv
hw/rtl/cartridge_bank_address_mapper.sv
tb/tb.sv
